/* design/assembly_source_lexer_defines.svh */
// assertion macros shared by the lexer rtl
// expects clk and arst_n in the scope of every use
`ifndef ASSEMBLY_SOURCE_LEXER_DEFINES_SVH
`define ASSEMBLY_SOURCE_LEXER_DEFINES_SVH

// condition holds at every edge out of reset
`define ASL_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define ASL_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/asl_pkg.sv */
// types, codes and sizing constants of the assembly source lexer
// no dependencies
`default_nettype none

package asl_pkg;

	localparam int LINE_BITS_DEF = 20;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF = 16;

	// queue depths, powers of two
	localparam int ITEM_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	typedef logic [19:0] line_t;
	typedef logic [15:0] col_t;
	typedef logic [15:0] len_t;

	typedef enum logic [2:0] {
		TK_NUMBER,
		TK_MNEMONIC,
		TK_LABEL,
		TK_DIRECTIVE,
		TK_STRING,
		TK_EOL,
		TK_END,
		TK_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_UNEXPECTED,
		ERR_UNTERMINATED
	} err_t;

	typedef enum logic [3:0] {
		M_FRESH,
		M_IDLE,
		M_COMMENT,
		M_MINUS,
		M_DEC,
		M_HEX,
		M_IDENT,
		M_STR,
		M_STR_ESC,
		M_ERROR
	} mode_t;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
	} in_t;

	typedef struct packed {
		kind_t       token_kind;
		logic [63:0] number_value;
		line_t       start_line;
		col_t        start_column;
		len_t        text_length;
		err_t        error_code;
		logic        last_of_run;
	} out_t;

	// byte classes worked out by the front end
	typedef struct packed {
		logic       op;
		logic       ws;
		logic       nl;
		logic       semi;
		logic       minus;
		logic       digit;
		logic       id_start;
		logic       id_char;
		logic       dot;
		logic       quote;
		logic       colon;
		logic       bslash;
		logic       xch;
		logic       hex_ok;
		logic [3:0] hex_val;
	} cls_t;

endpackage

`default_nettype wire

/* design/asl_fifo.sv */
// small flop queue taking zero, one or two entries per cycle, one out
// depends on the assertion macros; DEPTH must be a power of two
`default_nettype none
`include "assembly_source_lexer_defines.svh"

module asl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [1:0]                     push_n,
	input  wire logic [WIDTH-1:0]               wdata0,
	input  wire logic [WIDTH-1:0]               wdata1,
	input  wire logic                           pop,
	output logic      [WIDTH-1:0]               rdata,
	output logic      [$clog2(DEPTH+1)-1:0]     level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW-1:0]    wp1;
	logic [CW-1:0]    level_q;

	assign wp1 = wp_q + AW'(1);
	assign rdata = mem_q[rp_q];
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= wdata0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			level_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(push_n);
			rp_q <= rp_q + AW'(pop);
			level_q <= level_q + CW'(push_n) - CW'(pop);
		end
	end

	`ASL_ASSERT_ALWAYS(a_level_bound, level_q <= CW'(DEPTH), "queue level beyond depth")
	`ASL_ASSERT_IMPL(a_pop_nonempty, pop, level_q != '0, "pop from empty queue")

endmodule

`default_nettype wire

/* design/asl_front.sv */
// front end: input register and byte classification
// depends on asl_pkg
`default_nettype none

module asl_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         src_valid,
	output logic              src_ready,
	input  wire asl_pkg::in_t src_item,
	input  wire logic         q_room,
	output logic              push,
	output asl_pkg::cls_t     cls
);

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_X_LO = 8'h78;

	logic          valid_s1;
	asl_pkg::cls_t cls_s1;
	asl_pkg::cls_t cls_new;
	logic [7:0]    c;
	logic          digit;
	logic          alpha;
	logic          hex_letter;
	logic          accept;

	assign c = src_item.ch;
	assign digit = (c >= 8'h30) && (c <= 8'h39);
	assign alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	assign hex_letter = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));

	always_comb begin
		cls_new.op = src_item.op;
		cls_new.ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
		cls_new.nl = (c == CH_NL);
		cls_new.semi = (c == CH_SEMI);
		cls_new.minus = (c == CH_MINUS);
		cls_new.digit = digit;
		cls_new.id_start = alpha || (c == CH_UNDER) || (c == CH_DOT);
		cls_new.id_char = alpha || digit || (c == CH_UNDER) || (c == CH_DOT);
		cls_new.dot = (c == CH_DOT);
		cls_new.quote = (c == CH_QUOTE);
		cls_new.colon = (c == CH_COLON);
		cls_new.bslash = (c == CH_BSLASH);
		cls_new.xch = (c == CH_X_LO) || (c == CH_X_UP);
		cls_new.hex_ok = digit || hex_letter;
		cls_new.hex_val = digit ? c[3:0] : (c[3:0] + 4'd9);
	end

	assign push = valid_s1 && q_room;
	assign src_ready = !valid_s1 || q_room;
	assign accept = src_valid && src_ready;
	assign cls = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1 <= cls_new;
		end
	end

endmodule

`default_nettype wire

/* design/asl_back.sv */
// back end: lexer state and token generation, up to two tokens per item
// depends on asl_pkg and the assertion macros
`default_nettype none
`include "assembly_source_lexer_defines.svh"

module asl_back #(
	parameter int LINE_BITS = asl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = asl_pkg::COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = asl_pkg::LENGTH_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	input  wire logic          room,
	input  wire asl_pkg::cls_t item,
	output logic               take,
	output logic [1:0]         res_n,
	output asl_pkg::out_t      res0,
	output asl_pkg::out_t      res1
);

	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
	localparam logic [COLUMN_BITS-1:0] COL_ONE = COLUMN_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

	asl_pkg::mode_t mode_q, mode_d;
	logic [63:0] acc_q, acc_d;
	logic neg_q, neg_d;
	logic zero_q, zero_d;
	logic dot_q, dot_d;
	logic [LINE_BITS-1:0] tline_q, tline_d, cline_q, cline_d;
	logic [COLUMN_BITS-1:0] tcol_q, tcol_d, ccol_q, ccol_d;
	logic [LENGTH_BITS-1:0] tlen_q, tlen_d;

	logic [LINE_BITS-1:0] line_adv;
	logic [COLUMN_BITS-1:0] col_adv;
	logic [LENGTH_BITS-1:0] tlen_inc;
	logic [63:0] acc_x10;
	logic [63:0] num_val;
	logic is_zero;
	logic in_error;
	logic at_fresh;

	logic ea, eb, rest, adv;
	asl_pkg::out_t tok_a, tok_b;
	asl_pkg::out_t tok_num, tok_ident, tok_end;

	function automatic asl_pkg::out_t mk_tok(asl_pkg::kind_t k, logic [63:0] v,
		asl_pkg::line_t l, asl_pkg::col_t c, asl_pkg::len_t n, asl_pkg::err_t e);
		asl_pkg::out_t t;
		t.token_kind = k;
		t.number_value = v;
		t.start_line = l;
		t.start_column = c;
		t.text_length = n;
		t.error_code = e;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	assign take = item_valid && room;

	// saturating position and length counters
	assign line_adv = item.nl ? (cline_q + {{(LINE_BITS-1){1'b0}}, ~&cline_q}) : cline_q;
	assign col_adv = item.nl ? COL_ONE : (ccol_q + {{(COLUMN_BITS-1){1'b0}}, ~&ccol_q});
	assign tlen_inc = tlen_q + {{(LENGTH_BITS-1){1'b0}}, ~&tlen_q};

	assign acc_x10 = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + {60'd0, item.hex_val};
	assign num_val = neg_q ? (~acc_q + 64'd1) : acc_q;
	assign is_zero = (item.hex_val == 4'd0);

	always_comb begin
		tok_num = mk_tok(asl_pkg::TK_NUMBER, num_val, asl_pkg::line_t'(tline_q),
			asl_pkg::col_t'(tcol_q), asl_pkg::len_t'(tlen_q), asl_pkg::ERR_NONE);
		tok_ident = mk_tok(dot_q ? asl_pkg::TK_DIRECTIVE : asl_pkg::TK_MNEMONIC, 64'd0,
			asl_pkg::line_t'(tline_q), asl_pkg::col_t'(tcol_q),
			asl_pkg::len_t'(tlen_q), asl_pkg::ERR_NONE);
		tok_end = mk_tok(asl_pkg::TK_END, 64'd0, asl_pkg::line_t'(cline_q),
			asl_pkg::col_t'(ccol_q), asl_pkg::len_t'(0), asl_pkg::ERR_NONE);
	end

	always_comb begin
		mode_d = mode_q;
		acc_d = acc_q;
		neg_d = neg_q;
		zero_d = zero_q;
		dot_d = dot_q;
		tline_d = tline_q;
		tcol_d = tcol_q;
		tlen_d = tlen_q;
		cline_d = cline_q;
		ccol_d = ccol_q;
		ea = 1'b0;
		eb = 1'b0;
		tok_a = '0;
		tok_b = '0;
		rest = 1'b0;
		adv = 1'b0;

		if (item.op) begin
			// end of source: flush a pending token, then start over
			case (mode_q)
				asl_pkg::M_IDLE, asl_pkg::M_COMMENT: begin
					ea = 1'b1;
					tok_a = tok_end;
				end
				asl_pkg::M_MINUS: begin
					ea = 1'b1;
					tok_a = mk_tok(asl_pkg::TK_ERROR, 64'd0, asl_pkg::line_t'(tline_q),
						asl_pkg::col_t'(tcol_q), asl_pkg::len_t'(0), asl_pkg::ERR_UNEXPECTED);
				end
				asl_pkg::M_DEC, asl_pkg::M_HEX: begin
					ea = 1'b1;
					tok_a = tok_num;
					eb = 1'b1;
					tok_b = tok_end;
				end
				asl_pkg::M_IDENT: begin
					ea = 1'b1;
					tok_a = tok_ident;
					eb = 1'b1;
					tok_b = tok_end;
				end
				asl_pkg::M_STR, asl_pkg::M_STR_ESC: begin
					ea = 1'b1;
					tok_a = mk_tok(asl_pkg::TK_ERROR, 64'd0, asl_pkg::line_t'(cline_q),
						asl_pkg::col_t'(ccol_q), asl_pkg::len_t'(0), asl_pkg::ERR_UNTERMINATED);
				end
				default: begin
					ea = 1'b0;
				end
			endcase
			mode_d = asl_pkg::M_FRESH;
			acc_d = '0;
			neg_d = 1'b0;
			zero_d = 1'b0;
			dot_d = 1'b0;
			tline_d = LINE_ONE;
			tcol_d = COL_ONE;
			tlen_d = '0;
			cline_d = LINE_ONE;
			ccol_d = COL_ONE;
		end else begin
			case (mode_q)
				asl_pkg::M_ERROR: begin
					rest = 1'b0;
				end
				asl_pkg::M_COMMENT: begin
					if (!item.nl) begin
						adv = 1'b1;
					end else begin
						rest = 1'b1;
					end
				end
				asl_pkg::M_MINUS: begin
					if (item.digit) begin
						acc_d = {60'd0, item.hex_val};
						zero_d = is_zero;
						tlen_d = tlen_inc;
						adv = 1'b1;
						mode_d = asl_pkg::M_DEC;
					end else begin
						ea = 1'b1;
						tok_a = mk_tok(asl_pkg::TK_ERROR, 64'd0, asl_pkg::line_t'(tline_q),
							asl_pkg::col_t'(tcol_q), asl_pkg::len_t'(0), asl_pkg::ERR_UNEXPECTED);
						mode_d = asl_pkg::M_ERROR;
					end
				end
				asl_pkg::M_DEC: begin
					if (item.digit) begin
						acc_d = acc_x10;
						zero_d = 1'b0;
						tlen_d = tlen_inc;
						adv = 1'b1;
					end else if (item.xch && zero_q) begin
						zero_d = 1'b0;
						acc_d = '0;
						mode_d = asl_pkg::M_HEX;
						tlen_d = tlen_inc;
						adv = 1'b1;
					end else begin
						ea = 1'b1;
						tok_a = tok_num;
						rest = 1'b1;
					end
				end
				asl_pkg::M_HEX: begin
					if (item.hex_ok) begin
						acc_d = {acc_q[59:0], item.hex_val};
						tlen_d = tlen_inc;
						adv = 1'b1;
					end else begin
						ea = 1'b1;
						tok_a = tok_num;
						rest = 1'b1;
					end
				end
				asl_pkg::M_IDENT: begin
					if (item.id_char) begin
						tlen_d = tlen_inc;
						adv = 1'b1;
					end else if (item.colon) begin
						ea = 1'b1;
						tok_a = tok_ident;
						tok_a.token_kind = asl_pkg::TK_LABEL;
						adv = 1'b1;
						mode_d = asl_pkg::M_IDLE;
					end else begin
						ea = 1'b1;
						tok_a = tok_ident;
						rest = 1'b1;
					end
				end
				asl_pkg::M_STR: begin
					if (item.nl) begin
						ea = 1'b1;
						tok_a = mk_tok(asl_pkg::TK_ERROR, 64'd0, asl_pkg::line_t'(cline_q),
							asl_pkg::col_t'(ccol_q), asl_pkg::len_t'(0), asl_pkg::ERR_UNTERMINATED);
						mode_d = asl_pkg::M_ERROR;
					end else begin
						tlen_d = tlen_inc;
						adv = 1'b1;
						if (item.bslash) begin
							mode_d = asl_pkg::M_STR_ESC;
						end else if (item.quote) begin
							ea = 1'b1;
							tok_a = mk_tok(asl_pkg::TK_STRING, 64'd0,
								asl_pkg::line_t'(tline_q), asl_pkg::col_t'(tcol_q),
								asl_pkg::len_t'(tlen_inc), asl_pkg::ERR_NONE);
							mode_d = asl_pkg::M_IDLE;
						end
					end
				end
				asl_pkg::M_STR_ESC: begin
					tlen_d = tlen_inc;
					adv = 1'b1;
					mode_d = asl_pkg::M_STR;
				end
				default: begin
					rest = 1'b1;
				end
			endcase

			// the byte that ended a token is lexed from scratch
			if (rest) begin
				mode_d = asl_pkg::M_IDLE;
				if (item.ws) begin
					adv = 1'b1;
				end else if (item.nl) begin
					eb = 1'b1;
					tok_b = mk_tok(asl_pkg::TK_EOL, 64'd0, asl_pkg::line_t'(cline_q),
						asl_pkg::col_t'(ccol_q), asl_pkg::len_t'(1), asl_pkg::ERR_NONE);
					adv = 1'b1;
				end else if (item.semi) begin
					mode_d = asl_pkg::M_COMMENT;
					adv = 1'b1;
				end else if (item.minus) begin
					tline_d = cline_q;
					tcol_d = ccol_q;
					tlen_d = LEN_ONE;
					neg_d = 1'b1;
					mode_d = asl_pkg::M_MINUS;
					adv = 1'b1;
				end else if (item.digit) begin
					tline_d = cline_q;
					tcol_d = ccol_q;
					tlen_d = LEN_ONE;
					neg_d = 1'b0;
					acc_d = {60'd0, item.hex_val};
					zero_d = is_zero;
					mode_d = asl_pkg::M_DEC;
					adv = 1'b1;
				end else if (item.id_start) begin
					tline_d = cline_q;
					tcol_d = ccol_q;
					tlen_d = LEN_ONE;
					dot_d = item.dot;
					mode_d = asl_pkg::M_IDENT;
					adv = 1'b1;
				end else if (item.quote) begin
					tline_d = cline_q;
					tcol_d = ccol_q;
					tlen_d = LEN_ONE;
					mode_d = asl_pkg::M_STR;
					adv = 1'b1;
				end else begin
					eb = 1'b1;
					tok_b = mk_tok(asl_pkg::TK_ERROR, 64'd0, asl_pkg::line_t'(cline_q),
						asl_pkg::col_t'(ccol_q), asl_pkg::len_t'(0), asl_pkg::ERR_UNEXPECTED);
					mode_d = asl_pkg::M_ERROR;
				end
			end

			if (adv) begin
				cline_d = line_adv;
				ccol_d = col_adv;
			end
		end
	end

	always_comb begin
		res0 = ea ? tok_a : tok_b;
		res0.last_of_run = !(ea && eb);
		res1 = tok_b;
		res1.last_of_run = 1'b1;
		res_n = take ? {ea && eb, ea ^ eb} : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= asl_pkg::M_FRESH;
			acc_q <= '0;
			neg_q <= 1'b0;
			zero_q <= 1'b0;
			dot_q <= 1'b0;
			tline_q <= LINE_ONE;
			tcol_q <= COL_ONE;
			tlen_q <= '0;
			cline_q <= LINE_ONE;
			ccol_q <= COL_ONE;
		end else if (take) begin
			mode_q <= mode_d;
			acc_q <= acc_d;
			neg_q <= neg_d;
			zero_q <= zero_d;
			dot_q <= dot_d;
			tline_q <= tline_d;
			tcol_q <= tcol_d;
			tlen_q <= tlen_d;
			cline_q <= cline_d;
			ccol_q <= ccol_d;
		end
	end

	assign in_error = (mode_q == asl_pkg::M_ERROR);
	assign at_fresh = (mode_q == asl_pkg::M_FRESH);

	`ASL_ASSERT_NEXT(a_end_restarts, take && item.op, at_fresh, "end of source left lexer state")
	`ASL_ASSERT_IMPL(a_error_silent, take && !item.op && in_error, res_n == '0, "token after error")
	`ASL_ASSERT_ALWAYS(a_position_nonzero, (cline_q != '0) && (ccol_q != '0), "line or column at zero")

endmodule

`default_nettype wire

/* design/assembly_source_lexer.sv */
// assembly source lexer top level: front end, item queue, back end, token queue
// depends on asl_pkg, asl_front, asl_fifo and asl_back
//
// Usage:
//   src channel (src_valid/src_ready/src_item): one item per source byte,
//   op = 0 with the byte in ch, or op = 1 to mark end of source.
//   tok channel (tok_valid/tok_ready/tok_item): zero, one or two tokens per
//   item; last_of_run marks the final token an item produced.
//   A token passes through the input register, then the item queue, then the
//   token queue before it is offered.
//   Throughput: one item per cycle while tokens are drained; an item that
//   makes two tokens slows the token side, since the token queue hands out
//   one token per cycle.
//   The lexer stage takes an item only with two free token queue slots.
//   When the receiver stalls, the four-entry token queue fills, then the
//   two-entry item queue and the input register, and src_ready drops.
//   Reset empties both queues and puts the lexer at line 1, column 1,
//   with no source seen. Every end of source returns it to that state.
`default_nettype none

module assembly_source_lexer #(
	parameter int LINE_BITS = asl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = asl_pkg::COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = asl_pkg::LENGTH_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         src_valid,
	output logic              src_ready,
	input  wire asl_pkg::in_t src_item,
	output logic              tok_valid,
	input  wire logic         tok_ready,
	output asl_pkg::out_t     tok_item
);

	localparam int CLS_W = $bits(asl_pkg::cls_t);
	localparam int OUT_W = $bits(asl_pkg::out_t);
	localparam int ITEM_CW = $clog2(asl_pkg::ITEM_DEPTH + 1);
	localparam int RES_CW = $clog2(asl_pkg::RES_DEPTH + 1);

	logic                 push;
	asl_pkg::cls_t        cls_s1;
	logic [ITEM_CW-1:0]   item_level;
	logic [CLS_W-1:0]     item_rdata;
	logic                 item_room;
	asl_pkg::cls_t        item_head;
	logic                 take;
	logic [1:0]           res_n;
	asl_pkg::out_t        res0;
	asl_pkg::out_t        res1;
	logic [RES_CW-1:0]    res_level;
	logic [OUT_W-1:0]     res_rdata;
	logic                 res_room;
	logic                 tok_pop;

	assign item_room = item_level != ITEM_CW'(asl_pkg::ITEM_DEPTH);
	assign item_head = asl_pkg::cls_t'(item_rdata);
	assign res_room = res_level <= RES_CW'(asl_pkg::RES_DEPTH - 2);
	assign tok_valid = res_level != '0;
	assign tok_pop = tok_valid && tok_ready;
	assign tok_item = asl_pkg::out_t'(res_rdata);

	asl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.q_room    (item_room),
		.push      (push),
		.cls       (cls_s1)
	);

	asl_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (asl_pkg::ITEM_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n ({1'b0, push}),
		.wdata0 (cls_s1),
		.wdata1 (cls_s1),
		.pop    (take),
		.rdata  (item_rdata),
		.level  (item_level)
	);

	asl_back #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_level != '0),
		.room       (res_room),
		.item       (item_head),
		.take       (take),
		.res_n      (res_n),
		.res0       (res0),
		.res1       (res1)
	);

	asl_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (asl_pkg::RES_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (res_n),
		.wdata0 (res0),
		.wdata1 (res1),
		.pop    (tok_pop),
		.rdata  (res_rdata),
		.level  (res_level)
	);

endmodule

`default_nettype wire

/* test/lexer_token_pkg.sv */
`timescale 1ns / 100ps
// token predictor and scoreboard for the assembly source lexer testbench
// depends on asl_pkg for the item types and token codes

package lexer_token_pkg;

	import asl_pkg::*;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_ident_char(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_" || c == ".";
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (is_digit(c)) return int'(c - 8'h30);
		if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
		if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	class lexer_token_model;
		out_t expected_tokens[$];
		int failures;
		int lexed_items;

		mode_t mode;
		logic [63:0] acc;
		bit negative;
		bit lone_zero;
		bit dot_lead;
		line_t tok_line;
		col_t tok_col;
		len_t tok_len;
		line_t cur_line;
		col_t cur_col;

		function new();
			failures = 0;
			lexed_items = 0;
			clear_state();
		endfunction

		function void clear_state();
			mode = M_FRESH;
			acc = '0;
			negative = 1'b0;
			lone_zero = 1'b0;
			dot_lead = 1'b0;
			tok_line = 1;
			tok_col = 1;
			tok_len = 0;
			cur_line = 1;
			cur_col = 1;
		endfunction

		function int pending();
			return expected_tokens.size();
		endfunction

		function void queue_token(out_t t);
			expected_tokens = {expected_tokens, t};
		endfunction

		function void add_token(kind_t kind, logic [63:0] value, line_t at_line, col_t at_col,
				len_t length, err_t err);
			out_t t;
			t.token_kind = kind;
			t.number_value = value;
			t.start_line = at_line;
			t.start_column = at_col;
			t.text_length = length;
			t.error_code = err;
			t.last_of_run = 1'b0;
			queue_token(t);
		endfunction

		// saturating position counters
		function void step_column(logic [7:0] c);
			if (c == 8'h0a) begin
				if (cur_line != '1) cur_line++;
				cur_col = 1;
			end else if (cur_col != '1) begin
				cur_col++;
			end
		endfunction

		function void grow_token();
			if (tok_len != '1) tok_len++;
		endfunction

		function void open_token();
			tok_line = cur_line;
			tok_col = cur_col;
			tok_len = 1;
		endfunction

		function void add_number();
			add_token(TK_NUMBER, negative ? -acc : acc, tok_line, tok_col, tok_len, ERR_NONE);
		endfunction

		function void add_ident(bit label);
			kind_t kind;
			if (label) kind = TK_LABEL;
			else if (dot_lead) kind = TK_DIRECTIVE;
			else kind = TK_MNEMONIC;
			add_token(kind, '0, tok_line, tok_col, tok_len, ERR_NONE);
		endfunction

		function void add_end();
			add_token(TK_END, '0, cur_line, cur_col, '0, ERR_NONE);
		endfunction

		// byte seen between tokens
		function void lex_fresh(logic [7:0] c);
			mode = M_IDLE;
			if (c == " " || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d) begin
				step_column(c);
			end else if (c == 8'h0a) begin
				add_token(TK_EOL, '0, cur_line, cur_col, 1, ERR_NONE);
				step_column(c);
			end else if (c == ";") begin
				mode = M_COMMENT;
				step_column(c);
			end else if (c == "-") begin
				open_token();
				negative = 1'b1;
				mode = M_MINUS;
				step_column(c);
			end else if (is_digit(c)) begin
				open_token();
				negative = 1'b0;
				acc = 64'(c - 8'h30);
				lone_zero = (c == "0");
				mode = M_DEC;
				step_column(c);
			end else if (is_alpha(c) || c == "_" || c == ".") begin
				open_token();
				dot_lead = (c == ".");
				mode = M_IDENT;
				step_column(c);
			end else if (c == 8'h22) begin
				open_token();
				mode = M_STR;
				step_column(c);
			end else begin
				add_token(TK_ERROR, '0, cur_line, cur_col, '0, ERR_UNEXPECTED);
				mode = M_ERROR;
			end
		endfunction

		function void lex_item(in_t it);
			logic [7:0] c;
			bit rest;
			int h;
			int first;
			out_t t;
			c = it.ch;
			rest = 1'b1;
			first = expected_tokens.size();
			if (it.op) begin
				lexed_items++;
				case (mode)
					M_IDLE, M_COMMENT: add_end();
					M_MINUS: add_token(TK_ERROR, '0, tok_line, tok_col, '0, ERR_UNEXPECTED);
					M_DEC, M_HEX: begin
						add_number();
						add_end();
					end
					M_IDENT: begin
						add_ident(1'b0);
						add_end();
					end
					M_STR, M_STR_ESC: begin
						add_token(TK_ERROR, '0, cur_line, cur_col, '0, ERR_UNTERMINATED);
					end
					default: ;
				endcase
				clear_state();
			end else if (mode != M_ERROR) begin
				lexed_items++;
				case (mode)
					M_COMMENT: begin
						if (c != 8'h0a) begin
							step_column(c);
							rest = 1'b0;
						end
					end
					M_MINUS: begin
						if (is_digit(c)) begin
							acc = 64'(c - 8'h30);
							lone_zero = (c == "0");
							grow_token();
							step_column(c);
							mode = M_DEC;
						end else begin
							add_token(TK_ERROR, '0, tok_line, tok_col, '0, ERR_UNEXPECTED);
							mode = M_ERROR;
						end
						rest = 1'b0;
					end
					M_DEC: begin
						if (is_digit(c)) begin
							acc = acc * 64'd10 + 64'(c - 8'h30);
							lone_zero = 1'b0;
							grow_token();
							step_column(c);
							rest = 1'b0;
						end else if ((c == "x" || c == "X") && lone_zero) begin
							lone_zero = 1'b0;
							acc = '0;
							mode = M_HEX;
							grow_token();
							step_column(c);
							rest = 1'b0;
						end else begin
							add_number();
						end
					end
					M_HEX: begin
						h = hex_digit(c);
						if (h >= 0) begin
							acc = acc * 64'd16 + 64'(h);
							grow_token();
							step_column(c);
							rest = 1'b0;
						end else begin
							add_number();
						end
					end
					M_IDENT: begin
						if (is_ident_char(c)) begin
							grow_token();
							step_column(c);
							rest = 1'b0;
						end else if (c == ":") begin
							add_ident(1'b1);
							step_column(c);
							mode = M_IDLE;
							rest = 1'b0;
						end else begin
							add_ident(1'b0);
						end
					end
					M_STR: begin
						if (c == 8'h0a) begin
							add_token(TK_ERROR, '0, cur_line, cur_col, '0, ERR_UNTERMINATED);
							mode = M_ERROR;
						end else begin
							grow_token();
							step_column(c);
							if (c == 8'h5c) begin
								mode = M_STR_ESC;
							end else if (c == 8'h22) begin
								add_token(TK_STRING, '0, tok_line, tok_col, tok_len, ERR_NONE);
								mode = M_IDLE;
							end
						end
						rest = 1'b0;
					end
					M_STR_ESC: begin
						grow_token();
						step_column(c);
						mode = M_STR;
						rest = 1'b0;
					end
					default: ;
				endcase
				if (rest) lex_fresh(c);
			end
			if (expected_tokens.size() > first) begin
				t = expected_tokens.pop_back();
				t.last_of_run = 1'b1;
				queue_token(t);
			end
		endfunction

		function string describe(out_t t);
			return $sformatf("kind %0d value %h line %0d col %0d len %0d err %0d last %0d",
				t.token_kind, t.number_value, t.start_line, t.start_column, t.text_length,
				t.error_code, t.last_of_run);
		endfunction

		function void match_token(out_t got);
			out_t want;
			if (expected_tokens.size() == 0) begin
				failures++;
				if (failures <= 10) $display("token with none pending: %s", describe(got));
				return;
			end
			want = expected_tokens.pop_front();
			if (got.token_kind !== want.token_kind || got.number_value !== want.number_value ||
					got.start_line !== want.start_line || got.start_column !== want.start_column ||
					got.text_length !== want.text_length || got.error_code !== want.error_code ||
					got.last_of_run !== want.last_of_run) begin
				failures++;
				if (failures <= 10) begin
					$display("token mismatch");
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

endpackage

/* test/tb_top.sv */
`timescale 1ns / 100ps
// top of the assembly source lexer testbench: clock, reset, source and token drivers
// depends on asl_pkg, lexer_token_pkg and the assembly_source_lexer rtl

module tb_top;

	import asl_pkg::*;
	import lexer_token_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int QUOTA = 600;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	in_t src_item = '0;
	logic tok_valid;
	logic tok_ready = 1'b0;
	out_t tok_item;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	lexer_token_model token_model;

	assembly_source_lexer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item(src_item),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_item(tok_item)
	);

	always #5 clk = ~clk;

	// token side backpressure, with one long hold on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			tok_ready <= 1'b0;
		end else begin
			tok_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_valid && tok_ready) token_model.match_token(tok_item);
			if ((src_valid && src_ready) || (tok_valid && tok_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles < STALL_LIMIT) begin
				stall_cycles <= stall_cycles + 1;
			end else begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(in_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_valid <= 1'b1;
		src_item <= it;
		do @(posedge clk); while (!src_ready);
		token_model.lex_item(it);
	endtask

	task automatic send_byte(logic [7:0] c);
		send_item({1'b0, c});
	endtask

	task automatic send_end(logic [7:0] c);
		send_item({1'b1, c});
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	function automatic logic [7:0] ident_char(bit first);
		int r;
		r = $urandom_range(63);
		if (first && r >= 52 && r <= 61) r = r - 52;
		if (r < 26) return 8'h61 + 8'(r);
		if (r < 52) return 8'h41 + 8'(r - 26);
		if (r < 62) return 8'h30 + 8'(r - 52);
		return (r == 62) ? "_" : ".";
	endfunction

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(21);
		if (r < 10) return 8'h30 + 8'(r);
		if (r < 16) return 8'h61 + 8'(r - 10);
		return 8'h41 + 8'(r - 16);
	endfunction

	function automatic logic [7:0] space_char();
		case ($urandom_range(4))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0b;
			3: return 8'h0c;
			default: return 8'h0d;
		endcase
	endfunction

	// any byte but newline, quote and backslash
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == 8'h0a || b == 8'h22 || b == 8'h5c);
		return b;
	endfunction

	task automatic send_random_token();
		int pick;
		int n;
		int r;
		pick = $urandom_range(99);
		if (pick < 25) begin
			send_byte(ident_char(1'b1));
			n = $urandom_range(7);
			repeat (n) send_byte(ident_char(1'b0));
			if ($urandom_range(2) == 0) send_byte(":");
		end else if (pick < 50) begin
			if ($urandom_range(4) == 0) send_byte("-");
			if ($urandom_range(1) == 1) begin
				send_byte("0");
				send_byte(($urandom_range(1) == 1) ? "x" : "X");
				n = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(4);
				repeat (n) send_byte(hex_char());
			end else begin
				n = ($urandom_range(4) == 0) ? $urandom_range(1, 25) : $urandom_range(1, 4);
				repeat (n) send_byte(8'h30 + 8'($urandom_range(9)));
			end
		end else if (pick < 65) begin
			send_byte(8'h22);
			n = $urandom_range(10);
			repeat (n) begin
				r = $urandom_range(99);
				if (r < 12) begin
					send_byte(8'h5c);
					send_byte(8'($urandom_range(255)));
				end else if (r < 15) begin
					send_byte(8'h0a);
				end else begin
					send_byte(plain_byte());
				end
			end
			if ($urandom_range(19) != 0) send_byte(8'h22);
		end else if (pick < 75) begin
			send_byte(";");
			n = $urandom_range(8);
			repeat (n) send_byte(plain_byte());
			if ($urandom_range(4) != 0) send_byte(8'h0a);
		end else if (pick < 85) begin
			send_byte(8'h0a);
		end else if (pick < 95) begin
			send_byte(space_char());
		end else if (pick < 97) begin
			send_byte("-");
		end else begin
			send_byte(8'($urandom_range(255)));
		end
		r = $urandom_range(9);
		if (r < 5) send_byte(space_char());
		else if (r < 7) send_byte(8'h0a);
	endtask

	task automatic send_random_source();
		int n;
		n = $urandom_range(10);
		repeat (n) send_random_token();
		send_end(8'($urandom_range(255)));
	endtask

	task automatic run_phase(int tx_pct, int rx_pct, int quota);
		int stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at = token_model.lexed_items + quota;
		while (token_model.lexed_items < stop_at) send_random_source();
		@(negedge clk);
		src_valid <= 1'b0;
		while (token_model.pending() != 0) @(posedge clk);
	endtask

	initial begin
		token_model = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 8;
		rx_idle_pct = 63;
		// empty source
		send_end(8'hff);
		// escaped newline in a string closed by the last byte
		send_text("\"a\\\n\"");
		send_end(8'h00);
		// lone minus, then an ignored byte and a silent end
		send_text("-x");
		send_byte(8'hff);
		send_end(8'h5a);
		// hex prefix with no digits, then a negative number at the end
		send_text("0x\n-7");
		send_end(8'h80);
		// raw newline in a string
		send_text("\"\n");
		send_end(8'h01);
		// end inside a string
		send_byte(8'h22);
		send_end(8'h7f);
		// byte above ascii
		send_byte(8'h80);
		send_end(8'h00);

		run_phase(8, 63, QUOTA);
		run_phase(63, 8, QUOTA);
		run_phase(0, 0, QUOTA / 2);

		hold_request = HOLD_CYCLES;
		run_phase(0, 0, QUOTA / 2);
		repeat (10) @(posedge clk);

		if (token_model.failures == 0 && token_model.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
